// File: sv/uri_host_percent_decoder_unit_defines.svh
// assertion helpers included by the top-level unit to check the decoder
`ifndef URI_HOST_PERCENT_DECODER_UNIT_DEFINES_SVH
`define URI_HOST_PERCENT_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UHPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uhpd check failed");

// next-cycle implication, checked outside reset
`define UHPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uhpd check failed");

`endif

// File: sv/uhpd_pkg.sv
`default_nettype none

package uhpd_pkg;

    localparam int MaxRes = 4;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_QM  = 8'h3F;
    localparam logic [7:0] CH_SL  = 8'h2F;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_LP  = 8'h28;
    localparam logic [7:0] CH_RP  = 8'h29;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       text_end;
        logic       stopped_at_delimiter;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [7:0] la0;
        logic [7:0] la1;
        logic [1:0] la_cnt;
        logic       past_host;
        logic       halted;
    } t_state;

    // results of one item, entry 0 first
    typedef struct packed {
        t_out [MaxRes-1:0] res;
        logic [2:0]        cnt;
    } t_step;

endpackage

`default_nettype wire

// File: sv/uhpd_decode.sv
`default_nettype none

module uhpd_decode (
    input  wire uhpd_pkg::t_in    i_item,
    input  wire uhpd_pkg::t_state i_state,
    output uhpd_pkg::t_state      o_state,
    output uhpd_pkg::t_step       o_step
);

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    endfunction

    // only ever applied to hex digits, so four bits hold it
    function automatic logic [3:0] nibble(input logic [7:0] c);
        return c[3:0] + (c[6] ? 4'd9 : 4'd0);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == uhpd_pkg::CH_CR || c == uhpd_pkg::CH_LF || c == uhpd_pkg::CH_TAB ||
               c == uhpd_pkg::CH_SP || c == uhpd_pkg::CH_DQ || c == uhpd_pkg::CH_SQ ||
               c == uhpd_pkg::CH_LT || c == uhpd_pkg::CH_GT || c == uhpd_pkg::CH_LP ||
               c == uhpd_pkg::CH_RP;
    endfunction

    logic [7:0]  win [8];
    logic [1:0]  cnt_eff;
    logic [1:0]  n;
    logic [2:0]  pos;
    logic [2:0]  avail;
    logic [2:0]  k;
    logic [2:0]  rem;
    logic        done;
    logic        stop;
    logic        ph;
    logic        last;
    logic [7:0]  c;
    logic [7:0]  c1;
    logic [7:0]  c2;
    uhpd_pkg::t_out [uhpd_pkg::MaxRes-1:0] res;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            win[j] = 8'd0;
        end
        res     = '0;
        k       = 3'd0;
        pos     = 3'd0;
        avail   = 3'd0;
        done    = 1'b0;
        stop    = 1'b0;
        c       = 8'd0;
        c1      = 8'd0;
        c2      = 8'd0;
        rem     = 3'd0;
        last    = i_item.in_last;
        ph      = i_state.past_host;
        o_state = i_state;

        cnt_eff = (i_state.la_cnt > 2'd2) ? 2'd2 : i_state.la_cnt;
        n       = cnt_eff + 2'd1;
        case (cnt_eff)
            2'd0: begin
                win[0] = i_item.in_byte;
            end
            2'd1: begin
                win[0] = i_state.la0;
                win[1] = i_item.in_byte;
            end
            default: begin
                win[0] = i_state.la0;
                win[1] = i_state.la1;
                win[2] = i_item.in_byte;
            end
        endcase

        if (i_state.halted) begin
            if (last) begin
                o_state = '0;
            end
        end else begin
            // each pass consumes at least one byte of the window (up to three bytes) or ends the scan
            for (int it = 0; it < 3; it++) begin
                if (!done) begin
                    if (pos >= {1'b0, n}) begin
                        done = 1'b1;
                    end else begin
                        c     = win[pos];
                        c1    = win[pos + 3'd1];
                        c2    = win[pos + 3'd2];
                        avail = {1'b0, n} - pos;
                        if ((c == uhpd_pkg::CH_PCT || c == uhpd_pkg::CH_EQ) &&
                            avail < 3'd3 && !last) begin
                            done = 1'b1;
                        end else if ((c == uhpd_pkg::CH_PCT || (!ph && c == uhpd_pkg::CH_EQ)) &&
                                     avail >= 3'd3 && is_hex(c1) && is_hex(c2)) begin
                            res[k[1:0]].out_byte = to_lower({nibble(c1), nibble(c2)});
                            res[k[1:0]].has_byte = 1'b1;
                            k   = k + 3'd1;
                            pos = pos + 3'd3;
                        end else begin
                            if (c == uhpd_pkg::CH_QM || c == uhpd_pkg::CH_SL ||
                                c == uhpd_pkg::CH_BS) begin
                                ph = 1'b1;
                            end
                            if (c == uhpd_pkg::CH_EQ && avail >= 3'd2 &&
                                c1 == uhpd_pkg::CH_LF) begin
                                pos = pos + 3'd2;
                            end else if (c == uhpd_pkg::CH_EQ && avail >= 3'd3 &&
                                         c1 == uhpd_pkg::CH_CR && c2 == uhpd_pkg::CH_LF) begin
                                pos = pos + 3'd3;
                            end else if (is_delim(c)) begin
                                stop = 1'b1;
                                done = 1'b1;
                            end else begin
                                res[k[1:0]].out_byte = to_lower(c);
                                res[k[1:0]].has_byte = 1'b1;
                                k   = k + 3'd1;
                                pos = pos + 3'd1;
                            end
                        end
                    end
                end
            end

            o_state.past_host = ph;
            if (stop || last) begin
                res[k[1:0]].text_end             = 1'b1;
                res[k[1:0]].stopped_at_delimiter = stop;
                k = k + 3'd1;
                if (last) begin
                    o_state = '0;
                end else begin
                    o_state.la0    = 8'd0;
                    o_state.la1    = 8'd0;
                    o_state.la_cnt = 2'd0;
                    o_state.halted = 1'b1;
                end
            end else begin
                rem = {1'b0, n} - pos;
                if (rem > 3'd2) begin
                    rem = 3'd2;
                end
                o_state.la0    = (rem != 3'd0) ? win[pos] : 8'd0;
                o_state.la1    = (rem == 3'd2) ? win[pos + 3'd1] : 8'd0;
                o_state.la_cnt = rem[1:0];
            end
        end

        if (k != 3'd0) begin
            res[k[1:0] - 2'd1].run_last = 1'b1;
        end
        o_step.res = res;
        o_step.cnt = k;
    end

endmodule

`default_nettype wire

// File: sv/uhpd_resbuf.sv
`default_nettype none

module uhpd_resbuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  wire uhpd_pkg::t_step i_step,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire                  i_ready,
    output uhpd_pkg::t_out       o_item
);

    uhpd_pkg::t_out r_res [uhpd_pkg::MaxRes];
    logic [2:0]     r_left;
    logic [1:0]     r_idx;

    assign o_valid = (r_left != 3'd0);
    assign o_item  = r_res[r_idx];
    // room for a new item's results once the last pending one leaves
    assign o_free  = (r_left == 3'd0) || (r_left == 3'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (i_wr) begin
            r_left <= i_step.cnt;
            r_idx  <= 2'd0;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int j = 0; j < uhpd_pkg::MaxRes; j++) begin
                r_res[j] <= i_step.res[j];
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/uri_host_percent_decoder_unit.sv
// Percent decoder for URI text: takes one raw byte per item and hands out the decoded,
// lower-cased bytes, followed by an end marker when a delimiter or the final byte closes
// the text. An item is registered, decoded combinationally against up to two held-back
// lookahead bytes, and its results (up to four) land in a result buffer that drains one per
// cycle while the consumer is ready. The first result is offered once the item has passed the
// input register and the result buffer. Items are taken every cycle as long as each yields at
// most one result and the consumer is ready; an item that yields more results holds the buffer
// until its last result leaves, and the next item waits behind it in the input register.
`default_nettype none

module uri_host_percent_decoder_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire uhpd_pkg::t_in i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output uhpd_pkg::t_out     o_item
);

    logic             r_in_valid;
    uhpd_pkg::t_in    r_in;
    uhpd_pkg::t_state r_state;
    uhpd_pkg::t_state n_state;
    uhpd_pkg::t_step  dec_step;
    logic             buf_free;
    logic             fire;

    assign fire    = r_in_valid && buf_free;
    assign o_ready = !r_in_valid || fire;

    uhpd_decode u_decode (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_step  (dec_step)
    );

    uhpd_resbuf u_resbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fire),
        .i_step  (dec_step),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
    end

`include "uri_host_percent_decoder_unit_defines.svh"

    `UHPD_ASSERT_NEXT(a_results_shown, i_clk, i_rst_n, fire && dec_step.cnt != 3'd0, o_valid)
    `UHPD_ASSERT_IMPL(a_halt_no_lookahead, i_clk, i_rst_n, r_state.halted, r_state.la_cnt == 2'd0)
    `UHPD_ASSERT_IMPL(a_lookahead_bound, i_clk, i_rst_n, 1'b1, r_state.la_cnt != 2'd3)
    `UHPD_ASSERT_IMPL(a_end_no_byte, i_clk, i_rst_n, o_valid && o_item.text_end, !o_item.has_byte)

endmodule

`default_nettype wire
